@@ hw/rtl/dsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the detection statistics accumulator.
// Used by the top level and by its port checker; depends on nothing.
package dsa_pkg;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_TARGET_NOTE    = 2'd0;
    localparam cfg_index_t CFG_TARGET_WINDOWS = 2'd1;

    localparam logic [6:0] TARGET_NOTE_RESET    = 7'd0;
    localparam logic [7:0] TARGET_WINDOWS_RESET = 8'd10;

    // Restoring divider and square root step counts, and the number of divisions per row.
    localparam int DIV_STEPS  = 40;
    localparam int SQRT_STEPS = 20;
    localparam int NUM_DIVS   = 5;

    localparam logic [16:0] HIT_RATE_FULL = 17'd65536;

endpackage

@@ hw/rtl/detection_statistics_accumulator_top.sv @@
`timescale 1ns / 1ps
// Detection statistics accumulator: collects detections and emits summary rows.
// Depends on dsa_pkg. Holds a shared serial divider and a serial square root.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_mode s_note_hz ...    | in
//  result  | m_valid m_ready m_window_count ...      | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// A detection that does not close a row passes the square and accumulate states. A row
// then takes five 40-step divisions on one shared divider, a square, a
// subtract and a 20-step square root; an empty forced flush goes straight to emit.
// Input is ready only while the sequencer is idle; a waiting row holds the
// sequencer until the result register is free. Reset is synchronous, active low.
module detection_statistics_accumulator_top #(
    parameter int MAX_WINDOWS  = 255,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_mode,
    input  logic [15:0]         s_note_hz,
    input  logic [15:0]         s_confidence,
    input  logic [15:0]         s_magnitude,
    input  logic [6:0]          s_note_index,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_window_count,
    output logic [15:0]         m_mean_hz,
    output logic [15:0]         m_deviation_hz,
    output logic [15:0]         m_low_hz,
    output logic [15:0]         m_high_hz,
    output logic [15:0]         m_spread_hz,
    output logic [15:0]         m_mean_confidence,
    output logic [16:0]         m_hit_rate,
    output logic [15:0]         m_mean_magnitude,
    output logic [15:0]         m_peak_magnitude,
    output logic                m_was_forced,
    output logic                m_is_empty,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  dsa_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);
    import dsa_pkg::*;

    localparam logic [15:0] SMASK = (SAMPLE_WIDTH >= 16) ? 16'hFFFF
                                    : 16'((32'd1 << SAMPLE_WIDTH) - 32'd1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQUARE, ST_ACCUM, ST_DLOAD, ST_DIV,
        ST_MSQ, ST_VAR, ST_SQRT, ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [6:0]  target_note_reg;
    logic [7:0]  target_windows_reg;

    logic [7:0]  count_reg;
    logic [23:0] sum_hz_reg;
    logic [39:0] sum_sq_reg;
    logic [15:0] min_hz_reg;
    logic [15:0] max_hz_reg;
    logic [23:0] sum_conf_reg;
    logic [23:0] sum_mag_reg;
    logic [15:0] max_mag_reg;
    logic [7:0]  hits_reg;

    logic [15:0] hz_reg, conf_reg, mag_reg;
    logic [6:0]  idx_reg;
    logic [31:0] sq_reg;
    logic        forced_reg;

    logic [39:0] dvd_reg;
    logic [7:0]  rem_reg;
    logic [5:0]  step_reg;
    logic [2:0]  sel_reg;

    logic [15:0] mean_reg, mconf_reg, mmag_reg;
    logic [16:0] hrate_reg;
    logic [39:0] msq_reg;
    logic [31:0] mm_reg;
    logic [39:0] var_reg;
    logic [22:0] srem_reg;
    logic [19:0] root_reg;

    logic        m_valid_reg;
    logic [7:0]  o_count_reg;
    logic [15:0] o_mean_reg, o_dev_reg, o_low_reg, o_high_reg, o_spread_reg;
    logic [15:0] o_mconf_reg, o_mmag_reg, o_peak_reg;
    logic [16:0] o_hrate_reg;
    logic        o_forced_reg, o_empty_reg;

    logic [7:0]  count_next;
    logic        row_due;
    logic [39:0] dividend;
    logic [8:0]  rem_shift;
    logic        div_ge;
    logic [7:0]  rem_next;
    logic [39:0] dvd_next;
    logic [22:0] srem_shift;
    logic [22:0] trial;
    logic        sqrt_ge;
    logic        out_free;
    logic        empty_row;

    assign count_next = count_reg + 8'd1;
    assign row_due    = (count_next >= target_windows_reg)
                     || (32'(count_next) >= MAX_WINDOWS);
    assign out_free   = !m_valid_reg || m_ready;
    assign empty_row  = (count_reg == 8'd0);

    always_comb begin
        case (sel_reg)
            3'd0:    dividend = {16'd0, sum_hz_reg};
            3'd1:    dividend = sum_sq_reg;
            3'd2:    dividend = {16'd0, sum_conf_reg};
            3'd3:    dividend = {16'd0, sum_mag_reg};
            default: dividend = {16'd0, hits_reg, 16'd0};
        endcase
    end

    // One restoring division step: the remainder stays below the 8-bit count.
    assign rem_shift = {rem_reg, dvd_reg[39]};
    assign div_ge    = rem_shift >= {1'b0, count_reg};
    assign rem_next  = div_ge ? 8'(rem_shift - {1'b0, count_reg}) : rem_shift[7:0];
    assign dvd_next  = {dvd_reg[38:0], div_ge};

    // One digit-by-digit square root step over the next two bits of the variance.
    assign srem_shift = {srem_reg[20:0], var_reg[39:38]};
    assign trial      = {1'b0, root_reg, 2'b01};
    assign sqrt_ge    = srem_shift >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            target_note_reg    <= TARGET_NOTE_RESET;
            target_windows_reg <= TARGET_WINDOWS_RESET;
            count_reg          <= 8'd0;
            sum_hz_reg         <= 24'd0;
            sum_sq_reg         <= 40'd0;
            min_hz_reg         <= 16'hFFFF;
            max_hz_reg         <= 16'd0;
            sum_conf_reg       <= 24'd0;
            sum_mag_reg        <= 24'd0;
            max_mag_reg        <= 16'd0;
            hits_reg           <= 8'd0;
            m_valid_reg        <= 1'b0;
            step_reg           <= 6'd0;
            sel_reg            <= 3'd0;
            forced_reg         <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_TARGET_NOTE:    target_note_reg    <= cfg_data[6:0];
                    CFG_TARGET_WINDOWS: target_windows_reg <= cfg_data;
                    default: ;
                endcase
            end
            // The emit state loads the next row itself when the register frees up.
            if (m_valid_reg && m_ready && state_reg != ST_EMIT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        hz_reg     <= s_note_hz & SMASK;
                        conf_reg   <= s_confidence & SMASK;
                        mag_reg    <= s_magnitude & SMASK;
                        idx_reg    <= s_note_index;
                        forced_reg <= s_mode;
                        sel_reg    <= 3'd0;
                        if (s_mode) begin
                            state_reg <= (count_reg == 8'd0) ? ST_EMIT : ST_DLOAD;
                        end else begin
                            state_reg <= ST_SQUARE;
                        end
                    end
                end
                ST_SQUARE: begin
                    sq_reg    <= hz_reg * hz_reg;
                    state_reg <= ST_ACCUM;
                end
                ST_ACCUM: begin
                    count_reg    <= count_next;
                    sum_hz_reg   <= sum_hz_reg + {8'd0, hz_reg};
                    sum_sq_reg   <= sum_sq_reg + {8'd0, sq_reg};
                    if (count_next == 8'd1 || hz_reg < min_hz_reg) begin
                        min_hz_reg <= hz_reg;
                    end
                    if (hz_reg > max_hz_reg) begin
                        max_hz_reg <= hz_reg;
                    end
                    sum_conf_reg <= sum_conf_reg + {8'd0, conf_reg};
                    sum_mag_reg  <= sum_mag_reg + {8'd0, mag_reg};
                    if (mag_reg > max_mag_reg) begin
                        max_mag_reg <= mag_reg;
                    end
                    if (idx_reg == target_note_reg) begin
                        hits_reg <= hits_reg + 8'd1;
                    end
                    state_reg <= row_due ? ST_DLOAD : ST_IDLE;
                end
                ST_DLOAD: begin
                    dvd_reg   <= dividend;
                    rem_reg   <= 8'd0;
                    step_reg  <= 6'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(DIV_STEPS - 1)) begin
                        case (sel_reg)
                            3'd0:    mean_reg  <= dvd_next[15:0];
                            3'd1:    msq_reg   <= dvd_next;
                            3'd2:    mconf_reg <= dvd_next[15:0];
                            3'd3:    mmag_reg  <= dvd_next[15:0];
                            default: hrate_reg <= dvd_next[16:0];
                        endcase
                        sel_reg <= sel_reg + 3'd1;
                        state_reg <= (sel_reg == 3'(NUM_DIVS - 1)) ? ST_MSQ : ST_DLOAD;
                    end
                end
                ST_MSQ: begin
                    mm_reg    <= mean_reg * mean_reg;
                    state_reg <= ST_VAR;
                end
                ST_VAR: begin
                    var_reg   <= (msq_reg > {8'd0, mm_reg}) ? msq_reg - {8'd0, mm_reg} : 40'd0;
                    srem_reg  <= 23'd0;
                    root_reg  <= 20'd0;
                    step_reg  <= 6'd0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    var_reg  <= {var_reg[37:0], 2'b00};
                    step_reg <= step_reg + 6'd1;
                    if (sqrt_ge) begin
                        srem_reg <= srem_shift - trial;
                        root_reg <= {root_reg[18:0], 1'b1};
                    end else begin
                        srem_reg <= srem_shift;
                        root_reg <= {root_reg[18:0], 1'b0};
                    end
                    if (step_reg == 6'(SQRT_STEPS - 1)) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        o_count_reg  <= count_reg;
                        o_mean_reg   <= empty_row ? 16'd0 : mean_reg;
                        o_dev_reg    <= empty_row ? 16'd0 : root_reg[15:0];
                        o_low_reg    <= empty_row ? 16'd0 : min_hz_reg;
                        o_high_reg   <= empty_row ? 16'd0 : max_hz_reg;
                        o_spread_reg <= (empty_row || max_hz_reg < min_hz_reg) ? 16'd0
                                        : max_hz_reg - min_hz_reg;
                        o_mconf_reg  <= empty_row ? 16'd0 : mconf_reg;
                        o_hrate_reg  <= empty_row ? 17'd0 : hrate_reg;
                        o_mmag_reg   <= empty_row ? 16'd0 : mmag_reg;
                        o_peak_reg   <= empty_row ? 16'd0 : max_mag_reg;
                        o_forced_reg <= forced_reg;
                        o_empty_reg  <= empty_row;
                        count_reg    <= 8'd0;
                        sum_hz_reg   <= 24'd0;
                        sum_sq_reg   <= 40'd0;
                        min_hz_reg   <= 16'hFFFF;
                        max_hz_reg   <= 16'd0;
                        sum_conf_reg <= 24'd0;
                        sum_mag_reg  <= 24'd0;
                        max_mag_reg  <= 16'd0;
                        hits_reg     <= 8'd0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign cfg_ready         = 1'b1;
    assign m_valid           = m_valid_reg;
    assign m_window_count    = o_count_reg;
    assign m_mean_hz         = o_mean_reg;
    assign m_deviation_hz    = o_dev_reg;
    assign m_low_hz          = o_low_reg;
    assign m_high_hz         = o_high_reg;
    assign m_spread_hz       = o_spread_reg;
    assign m_mean_confidence = o_mconf_reg;
    assign m_hit_rate        = o_hrate_reg;
    assign m_mean_magnitude  = o_mmag_reg;
    assign m_peak_magnitude  = o_peak_reg;
    assign m_was_forced      = o_forced_reg;
    assign m_is_empty        = o_empty_reg;

endmodule

@@ hw/rtl/dsa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the detection statistics accumulator's result channel.
// Depends on dsa_pkg; bound to detection_statistics_accumulator_top below.
module dsa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_window_count,
    input logic [15:0] m_low_hz,
    input logic [15:0] m_high_hz,
    input logic [15:0] m_spread_hz,
    input logic [16:0] m_hit_rate,
    input logic        m_was_forced,
    input logic        m_is_empty
);
    import dsa_pkg::*;

    // A stalled row must hold.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_window_count) && $stable(m_hit_rate))
        else $error("result row changed while stalled");

    // Only a forced flush can give an empty row, and it carries no count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_empty |-> m_was_forced && m_window_count == 8'd0)
        else $error("empty row malformed");

    // A row with data has a count and a consistent frequency range.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_empty |-> m_window_count != 8'd0 && m_low_hz <= m_high_hz
            && m_spread_hz == m_high_hz - m_low_hz)
        else $error("row range inconsistent");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_hit_rate <= HIT_RATE_FULL)
        else $error("hit rate above one");

endmodule

bind detection_statistics_accumulator_top dsa_checker u_dsa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_window_count (m_window_count),
    .m_low_hz       (m_low_hz),
    .m_high_hz      (m_high_hz),
    .m_spread_hz    (m_spread_hz),
    .m_hit_rate     (m_hit_rate),
    .m_was_forced   (m_was_forced),
    .m_is_empty     (m_is_empty)
);

@@ dv/detection_statistics_accumulator_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for detection_statistics_accumulator_top.
// Needs dsa_pkg and the top level. It runs a directed table and then random
// detections under several idle patterns, checking every row against its own model.
module detection_statistics_accumulator_top_tb;
    import dsa_pkg::*;

    typedef struct packed {
        logic [7:0]  window_count;
        logic [15:0] mean_hz;
        logic [15:0] deviation_hz;
        logic [15:0] low_hz;
        logic [15:0] high_hz;
        logic [15:0] spread_hz;
        logic [15:0] mean_confidence;
        logic [16:0] hit_rate;
        logic [15:0] mean_magnitude;
        logic [15:0] peak_magnitude;
        logic        was_forced;
        logic        is_empty;
    } stats_row_t;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum logic {STEP_DETECT, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t  kind;
        cfg_index_t  reg_index;
        logic [7:0]  reg_data;
        logic        mode;
        logic [15:0] hz;
        logic [15:0] conf;
        logic [15:0] mag;
        logic [6:0]  idx;
        bit          typed;
        stats_row_t  row;
    } table_step_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int SETTLE_CYCLES  = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [15:0] s_note_hz = '0;
    logic [15:0] s_confidence = '0;
    logic [15:0] s_magnitude = '0;
    logic [6:0]  s_note_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    stats_row_t  got;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_TARGET_NOTE;
    logic [7:0]  cfg_data = '0;

    detection_statistics_accumulator_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_mode(s_mode), .s_note_hz(s_note_hz),
        .s_confidence(s_confidence), .s_magnitude(s_magnitude),
        .s_note_index(s_note_index),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_window_count(got.window_count), .m_mean_hz(got.mean_hz),
        .m_deviation_hz(got.deviation_hz), .m_low_hz(got.low_hz),
        .m_high_hz(got.high_hz), .m_spread_hz(got.spread_hz),
        .m_mean_confidence(got.mean_confidence), .m_hit_rate(got.hit_rate),
        .m_mean_magnitude(got.mean_magnitude), .m_peak_magnitude(got.peak_magnitude),
        .m_was_forced(got.was_forced), .m_is_empty(got.is_empty),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Model state.
    logic [6:0]  note_goal;
    logic [7:0]  windows_goal;
    logic [7:0]  acc_count;
    logic [23:0] acc_sum_hz;
    logic [39:0] acc_sum_sq;
    logic [15:0] acc_min_hz;
    logic [15:0] acc_max_hz;
    logic [23:0] acc_sum_conf;
    logic [23:0] acc_sum_mag;
    logic [15:0] acc_peak_mag;
    logic [7:0]  acc_hits;

    stats_row_t  pending_rows[$];
    idle_mode_t  idle_mode = IDLE_NONE;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          items_sent = 0;
    int          flushes_sent = 0;
    int          rows_seen = 0;
    int          writes_done = 0;

    function automatic void clear_stats();
        acc_count = '0;
        acc_sum_hz = '0;
        acc_sum_sq = '0;
        acc_min_hz = '1;
        acc_max_hz = '0;
        acc_sum_conf = '0;
        acc_sum_mag = '0;
        acc_peak_mag = '0;
        acc_hits = '0;
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] trial;
        r = 0;
        for (int i = 21; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= v) r = trial;
        end
        return r;
    endfunction

    function automatic stats_row_t summarize(logic forced);
        stats_row_t  row;
        logic [63:0] n, mean, msq, var_hz;
        row = '0;
        row.was_forced = forced;
        n = acc_count;
        if (n == 0) begin
            row.is_empty = 1'b1;
            return row;
        end
        mean = acc_sum_hz / n;
        msq = acc_sum_sq / n;
        var_hz = (msq > mean * mean) ? msq - mean * mean : 64'd0;
        row.window_count = n[7:0];
        row.mean_hz = mean[15:0];
        row.deviation_hz = 16'(root_floor(var_hz));
        row.low_hz = acc_min_hz;
        row.high_hz = acc_max_hz;
        row.spread_hz = acc_max_hz >= acc_min_hz ? acc_max_hz - acc_min_hz : 16'd0;
        row.mean_confidence = 16'(acc_sum_conf / n);
        row.hit_rate = 17'(({56'd0, acc_hits} << 16) / n);
        row.mean_magnitude = 16'(acc_sum_mag / n);
        row.peak_magnitude = acc_peak_mag;
        return row;
    endfunction

    // Advances the model by one request; returns 1 when a row is due.
    function automatic bit accumulate(logic mode, logic [15:0] hz, logic [15:0] conf,
                                      logic [15:0] mag, logic [6:0] idx,
                                      output stats_row_t row);
        if (mode) begin
            row = summarize(1'b1);
            clear_stats();
            return 1;
        end
        acc_count++;
        acc_sum_hz += hz;
        acc_sum_sq += 40'(hz) * 40'(hz);
        if (acc_count == 1 || hz < acc_min_hz) acc_min_hz = hz;
        if (hz > acc_max_hz) acc_max_hz = hz;
        acc_sum_conf += conf;
        acc_sum_mag += mag;
        if (mag > acc_peak_mag) acc_peak_mag = mag;
        if (idx == note_goal) acc_hits++;
        if (acc_count >= windows_goal || acc_count >= 8'd255) begin
            row = summarize(1'b0);
            clear_stats();
            return 1;
        end
        row = '0;
        return 0;
    endfunction

    task automatic compare_field(string name, logic [16:0] e, logic [16:0] g);
        if (e !== g) begin
            mismatches++;
            if (mismatches <= 10)
                $display("row %0d %s: expected %0d, got %0d", rows_seen, name, e, g);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready || m_valid && m_ready || cfg_valid && cfg_ready)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    always @(posedge aclk) begin
        case (idle_mode)
            IDLE_RECEIVER: m_ready <= $urandom_range(99) >= 88;
            IDLE_BOTH:     m_ready <= $urandom_range(99) >= 24;
            default:       m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        stats_row_t want;
        if (aresetn && m_valid && m_ready) begin
            rows_seen++;
            if (pending_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("row %0d arrived with none expected", rows_seen);
            end else begin
                want = pending_rows.pop_front();
                compare_field("window_count", want.window_count, got.window_count);
                compare_field("mean_hz", want.mean_hz, got.mean_hz);
                compare_field("deviation_hz", want.deviation_hz, got.deviation_hz);
                compare_field("low_hz", want.low_hz, got.low_hz);
                compare_field("high_hz", want.high_hz, got.high_hz);
                compare_field("spread_hz", want.spread_hz, got.spread_hz);
                compare_field("mean_confidence", want.mean_confidence, got.mean_confidence);
                compare_field("hit_rate", want.hit_rate, got.hit_rate);
                compare_field("mean_magnitude", want.mean_magnitude, got.mean_magnitude);
                compare_field("peak_magnitude", want.peak_magnitude, got.peak_magnitude);
                compare_field("was_forced", want.was_forced, got.was_forced);
                compare_field("is_empty", want.is_empty, got.is_empty);
            end
        end
    end

    // Drives one request and holds it until the block takes it.
    task automatic send_detection(logic mode, logic [15:0] hz, logic [15:0] conf,
                                  logic [15:0] mag, logic [6:0] idx,
                                  bit typed, stats_row_t typed_row);
        stats_row_t row;
        s_valid <= 1'b1;
        s_mode <= mode;
        s_note_hz <= hz;
        s_confidence <= conf;
        s_magnitude <= mag;
        s_note_index <= idx;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (mode) flushes_sent++;
        if (accumulate(mode, hz, conf, mag, idx, row))
            pending_rows.push_back(typed ? typed_row : row);
    endtask

    // Valid only drops when an idle gap follows it.
    task automatic sender_gap();
        int pct;
        if (idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) begin
            pct = (idle_mode == IDLE_SENDER) ? 88 : 24;
            if ($urandom_range(99) < pct) begin
                s_valid <= 1'b0;
                do @(posedge aclk); while ($urandom_range(99) < pct);
            end
        end
    endtask

    // Drains every pending row, lets an unfinished detection settle, then writes.
    task automatic write_register(cfg_index_t index, logic [7:0] data);
        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        writes_done++;
        if (index == CFG_TARGET_NOTE) note_goal = data[6:0];
        else if (index == CFG_TARGET_WINDOWS) windows_goal = data;
    endtask

    table_step_t steps[$];

    function automatic void add_detect(logic mode, logic [15:0] hz, logic [15:0] conf,
                                       logic [15:0] mag, logic [6:0] idx,
                                       bit typed = 0, stats_row_t row = '0);
        table_step_t t;
        t.kind = STEP_DETECT;
        t.reg_index = CFG_TARGET_NOTE;
        t.reg_data = '0;
        t.mode = mode;
        t.hz = hz;
        t.conf = conf;
        t.mag = mag;
        t.idx = idx;
        t.typed = typed;
        t.row = row;
        steps.push_back(t);
    endfunction

    function automatic void add_write(cfg_index_t index, logic [7:0] data);
        table_step_t t;
        t = '{STEP_WRITE, index, data, 1'b0, 16'd0, 16'd0, 16'd0, 7'd0, 0, '0};
        steps.push_back(t);
    endfunction

    function automatic logic [15:0] pick_hz(logic [15:0] center);
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return center + 16'($urandom_range(64)) - 16'd32;
        endcase
    endfunction

    initial begin
        stats_row_t  row_empty, row_top, row_zero;
        logic [15:0] center;
        logic [7:0]  goal;
        int          count_in_block;
        bit          no_flush;

        note_goal = TARGET_NOTE_RESET;
        windows_goal = TARGET_WINDOWS_RESET;
        clear_stats();

        row_empty = '0;
        row_empty.was_forced = 1'b1;
        row_empty.is_empty = 1'b1;
        row_top = '{8'd1, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF,
                    HIT_RATE_FULL, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0};
        row_zero = '0;
        row_zero.window_count = 8'd1;

        add_detect(1'b1, 16'd0, 16'd0, 16'd0, 7'd0, 1, row_empty);
        add_write(CFG_TARGET_WINDOWS, 8'd1);
        add_detect(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd0, 1, row_top);
        add_detect(1'b0, 16'h0000, 16'h0000, 16'h0000, 7'd127, 1, row_zero);
        add_write(CFG_TARGET_NOTE, 8'hFF);
        add_detect(1'b0, 16'h1B80, 16'h8000, 16'd300, 7'd127);
        add_write(CFG_TARGET_WINDOWS, 8'd0);
        add_detect(1'b0, 16'h0370, 16'h4000, 16'd77, 7'd5);
        add_write(CFG_TARGET_WINDOWS, 8'd255);
        add_detect(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
        add_detect(1'b0, 16'h0000, 16'h0000, 16'h0000, 7'd0);
        add_detect(1'b0, 16'h5555, 16'hAAAA, 16'h5555, 7'd42);
        add_detect(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA, 7'd127);
        add_detect(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd127);
        add_detect(1'b1, 16'd0, 16'd0, 16'd0, 7'd0, 1, row_empty);
        add_write(cfg_index_t'(2), 8'hFF);
        add_write(cfg_index_t'(3), 8'h00);
        add_write(CFG_TARGET_WINDOWS, 8'd5);
        add_detect(1'b0, 16'd440 << 4, 16'hF000, 16'd1000, 7'd127);
        add_detect(1'b0, 16'd442 << 4, 16'hE000, 16'd1200, 7'd69);
        add_detect(1'b0, 16'd438 << 4, 16'hD000, 16'd900, 7'd127);
        // Lowering the target below the collected count closes the row on the next one.
        add_write(CFG_TARGET_WINDOWS, 8'd2);
        add_detect(1'b0, 16'd441 << 4, 16'hC000, 16'd1100, 7'd127);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (steps[i]) begin
            if (steps[i].kind == STEP_WRITE)
                write_register(steps[i].reg_index, steps[i].reg_data);
            else
                send_detection(steps[i].mode, steps[i].hz, steps[i].conf, steps[i].mag,
                               steps[i].idx, steps[i].typed, steps[i].row);
        end

        for (int blk = 0; blk < 26; blk++) begin
            idle_mode = idle_mode_t'(blk % 4);
            no_flush = (blk == 5);
            case ($urandom_range(9))
                0:       goal = 8'd0;
                1:       goal = $urandom_range(1) ? 8'd255 : 8'd254;
                2:       goal = 8'($urandom_range(40, 100));
                default: goal = 8'($urandom_range(1, 16));
            endcase
            if (no_flush) goal = 8'd255;
            write_register(CFG_TARGET_WINDOWS, goal);
            write_register(CFG_TARGET_NOTE, 8'($urandom));
            if (blk % 7 == 3) write_register(cfg_index_t'($urandom_range(2, 3)), 8'($urandom));
            center = 16'($urandom_range(400, 60000));
            count_in_block = no_flush ? 260 : 51;
            for (int k = 0; k < count_in_block; k++) begin
                send_detection(!no_flush && $urandom_range(19) == 0, pick_hz(center),
                               16'($urandom), 16'($urandom),
                               $urandom_range(1) ? note_goal : 7'($urandom), 0, '0);
                sender_gap();
                // Now and then hold off until every row has been delivered.
                if (k == 30 && blk % 3 == 0) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (pending_rows.size() != 0);
                end
            end
        end

        s_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests (%0d forced flushes), %0d rows, %0d register writes.",
                 items_sent, flushes_sent, rows_seen, writes_done);
        $display("Idle patterns: none, sender, receiver and both; windows from 0 to 255.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
